// ===== rtl/prpe_pkg.sv =====
// ----------------------------------------------------------------------------
// prpe_pkg
// Shared types and constants for the page replacement policy engine.
// ----------------------------------------------------------------------------
package prpe_pkg;

	// Page id width fixed by the reference stream format
	localparam int PAGE_W = 8;

	// Policy codes
	localparam logic [2:0] MODE_FIFO     = 3'd0;
	localparam logic [2:0] MODE_LRU      = 3'd1;
	localparam logic [2:0] MODE_LFU      = 3'd2;
	localparam logic [2:0] MODE_MFU      = 3'd3;
	localparam logic [2:0] MODE_LFU_LRU  = 3'd4;
	localparam logic [2:0] MODE_MFU_LRU  = 3'd5;

	// Register indexes (word address bit)
	localparam logic REG_POLICY_MODE   = 1'b0;
	localparam logic REG_FRAMES_IN_USE = 1'b1;

	// Register reset values
	localparam logic [2:0] POLICY_MODE_RST   = MODE_FIFO;
	localparam logic [3:0] FRAMES_IN_USE_RST = 4'd8;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_SCAN_RD,
		ST_SCAN,
		ST_EVICT,
		ST_CNT_RD,
		ST_CNT_WR
	} state_t;

	// Frame list update command
	typedef struct packed {
		logic              shift;
		logic [PAGE_W-1:0] page;
	} frm_cmd_t;

	// Counter store command
	typedef struct packed {
		logic clear_all;
		logic wr_en;
	} cnt_cmd_t;

endpackage

// ===== rtl/prpe_regs.sv =====
// ----------------------------------------------------------------------------
// prpe_regs
// APB configuration registers: policy mode and frame limit.
// ----------------------------------------------------------------------------
module prpe_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [2:0]  policy_mode,
	output logic [3:0]  frames_in_use
);

	logic [2:0] mode_q;
	logic [3:0] frames_q;
	logic       wr_beat;

	assign pready  = 1'b1;
	assign wr_beat = psel && penable && pwrite;

	// Write on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= prpe_pkg::POLICY_MODE_RST;
			frames_q <= prpe_pkg::FRAMES_IN_USE_RST;
		end else if (wr_beat) begin
			unique case (paddr[2])
				prpe_pkg::REG_POLICY_MODE:   mode_q   <= pwdata[2:0];
				prpe_pkg::REG_FRAMES_IN_USE: frames_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (paddr[2])
			prpe_pkg::REG_POLICY_MODE:   prdata = {29'd0, mode_q};
			prpe_pkg::REG_FRAMES_IN_USE: prdata = {28'd0, frames_q};
			default:                     prdata = 32'd0;
		endcase
	end

	assign policy_mode   = mode_q;
	assign frames_in_use = frames_q;

endmodule

// ===== rtl/prpe_frames.sv =====
// ----------------------------------------------------------------------------
// prpe_frames
// Ordered frame list, newest at position 0, with one read port and a
// remove-and-push-front update.
// ----------------------------------------------------------------------------
module prpe_frames #(
	parameter int MAX_FRAMES = 8,
	parameter int IW         = 3
) (
	input  logic                           clk,
	input  prpe_pkg::frm_cmd_t             cmd,
	input  logic [IW-1:0]                  pos,
	input  logic [IW-1:0]                  rd_idx,
	output logic [prpe_pkg::PAGE_W-1:0]    rd_page
);

	logic [prpe_pkg::PAGE_W-1:0] fl_q [MAX_FRAMES];

	// Remove entry at pos, slide the ones in front of it back, push page in
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			fl_q[0] <= cmd.page;
			for (int k = 1; k < MAX_FRAMES; k++) begin
				if (IW'(k) <= pos) begin
					fl_q[k] <= fl_q[k-1];
				end
			end
		end
	end

	assign rd_page = fl_q[rd_idx];

endmodule

// ===== rtl/prpe_cnt_mem.sv =====
// ----------------------------------------------------------------------------
// prpe_cnt_mem
// Per-page reference counters: one write and one registered read port,
// with a valid bit per entry so a run clear drops every entry at once.
// ----------------------------------------------------------------------------
module prpe_cnt_mem #(
	parameter int PAGE_IDS   = 256,
	parameter int COUNT_BITS = 16,
	parameter int AW         = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  prpe_pkg::cnt_cmd_t    cmd,
	input  logic [AW-1:0]         rd_addr,
	input  logic [AW-1:0]         wr_addr,
	input  logic [COUNT_BITS-1:0] wr_data,
	output logic [COUNT_BITS-1:0] rd_data
);

	logic [COUNT_BITS-1:0] mem [PAGE_IDS];
	logic [PAGE_IDS-1:0]   valid_q;
	logic [COUNT_BITS-1:0] rd_q;
	logic                  rd_vld_q;

	// Store the counter
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Track written entries; a clear drops them all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= valid_q[rd_addr];
			if (cmd.clear_all) begin
				valid_q <= '0;
			end else if (cmd.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// Entries not written since the clear read as zero
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/page_replacement_policy_engine.sv =====
// ----------------------------------------------------------------------------
// page_replacement_policy_engine
// One page reference per command: frame search, victim choice for
// FIFO/LRU/LFU/MFU policies, list update and per-page reference counting.
// The search compares one frame entry a cycle; a count-policy replacement
//   then scans the frame counts through the single counter memory read
//   port before the counter update. Busy is low only in idle, where a new
//   reference is accepted.
// Reset empties the frame list and clears the counters (valid bits) and totals.
// ----------------------------------------------------------------------------
module page_replacement_policy_engine #(
	parameter int MAX_FRAMES = 8,
	parameter int PAGE_IDS   = 256,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  page_id,
	input  logic        first_of_run,
	// result channel
	output logic        done,
	output logic        was_fault,
	output logic        was_replaced,
	output logic [7:0]  victim_page,
	output logic [2:0]  hit_slot,
	output logic [3:0]  occupied_frames,
	output logic [31:0] fault_total,
	output logic [31:0] replace_total,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = $clog2(MAX_FRAMES + 1);
	localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int AW = $clog2(PAGE_IDS);
	localparam int PW = prpe_pkg::PAGE_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	prpe_pkg::state_t state_q, state_d;

	logic [2:0]  policy_mode;
	logic [3:0]  frames_in_use;

	// control registers
	logic [CW-1:0] count_q;
	logic [CW-1:0] j_q;
	logic [31:0]   faults_q;
	logic [31:0]   repl_q;
	logic          hit_q;
	logic          replaced_q;
	logic          zero_q;
	logic          done_q;

	// payload registers
	logic [PW-1:0]         page_q;
	logic [AW-1:0]         ci_q;
	logic [CW-1:0]         limit_q;
	logic                  lru_q;
	logic                  least_q;
	logic                  most_q;
	logic [IW-1:0]         slot_q;
	logic [IW-1:0]         pick_q;
	logic [COUNT_BITS-1:0] best_q;
	logic [PW-1:0]         victim_q;
	logic                  alias_s1;

	// datapath
	logic                  accept;
	logic                  match;
	logic                  search_last;
	logic                  room;
	logic                  count_mode;
	logic [CW-1:0]         count_m1;
	logic [CW-1:0]         j_p1;
	logic [AW-1:0]         ci_tab [256];
	logic [AW-1:0]         ci_in;
	logic [AW-1:0]         ci_rd;
	logic [COUNT_BITS-1:0] c_val;
	logic [COUNT_BITS-1:0] best_eff;
	logic                  take;
	logic [COUNT_BITS-1:0] old_cnt;
	logic [COUNT_BITS-1:0] new_cnt;
	logic [2:0]            mode_eff;
	logic [CW-1:0]         limit_in;
	logic [CW+3:0]         slot_ext;
	logic [CW+3:0]         count_ext;

	// frame list and counter store interface
	prpe_pkg::frm_cmd_t    frm_cmd;
	logic [IW-1:0]         frm_pos;
	logic [IW-1:0]         frm_rd_idx;
	logic [PW-1:0]         frm_rd_page;
	prpe_pkg::cnt_cmd_t    cnt_cmd;
	logic [AW-1:0]         cnt_rd_addr;
	logic [COUNT_BITS-1:0] cnt_rd_data;

	prpe_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.policy_mode   (policy_mode),
		.frames_in_use (frames_in_use)
	);

	prpe_frames #(
		.MAX_FRAMES (MAX_FRAMES),
		.IW         (IW)
	) u_frames (
		.clk     (clk),
		.cmd     (frm_cmd),
		.pos     (frm_pos),
		.rd_idx  (frm_rd_idx),
		.rd_page (frm_rd_page)
	);

	prpe_cnt_mem #(
		.PAGE_IDS   (PAGE_IDS),
		.COUNT_BITS (COUNT_BITS),
		.AW         (AW)
	) u_cnt_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cnt_cmd),
		.rd_addr (cnt_rd_addr),
		.wr_addr (ci_q),
		.wr_data (new_cnt),
		.rd_data (cnt_rd_data)
	);

	// Constant table: counter index of each page id
	for (genvar v = 0; v < 256; v++) begin : g_ci_tab
		assign ci_tab[v] = AW'(v % PAGE_IDS);
	end

	assign ci_in = ci_tab[page_id];
	assign ci_rd = ci_tab[frm_rd_page];

	// Decode policy and clamp the frame limit at the start beat
	assign mode_eff = (policy_mode > prpe_pkg::MODE_MFU_LRU) ? prpe_pkg::MODE_FIFO
	                                                         : policy_mode;
	always_comb begin
		if (frames_in_use == 4'd0) begin
			limit_in = CW'(1);
		end else if (32'(frames_in_use) > MAX_FRAMES) begin
			limit_in = CW'(MAX_FRAMES);
		end else begin
			limit_in = CW'(frames_in_use);
		end
	end

	assign accept      = start && (state_q == prpe_pkg::ST_IDLE);
	assign match       = (j_q < count_q) && (frm_rd_page == page_q);
	assign j_p1        = j_q + 1'b1;
	assign search_last = ({1'b0, j_q} + 1'b1) >= {1'b0, count_q};
	assign room        = count_q < limit_q;
	assign count_mode  = least_q || most_q;
	assign count_m1    = count_q - 1'b1;

	// Shared compare for the count scan
	assign c_val    = alias_s1 ? '0 : cnt_rd_data;
	assign best_eff = (j_q == '0) ? cnt_rd_data : best_q;
	assign take     = least_q ? (c_val <= best_eff) : (c_val >= best_eff);

	// Saturating counter bump
	assign old_cnt = zero_q ? '0 : cnt_rd_data;
	assign new_cnt = (old_cnt == CNT_MAX) ? old_cnt : old_cnt + 1'b1;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prpe_pkg::ST_IDLE: begin
				if (start) state_d = prpe_pkg::ST_SEARCH;
			end
			prpe_pkg::ST_SEARCH: begin
				if (search_last) state_d = prpe_pkg::ST_DECIDE;
			end
			prpe_pkg::ST_DECIDE: begin
				if (!hit_q && !room && count_mode) state_d = prpe_pkg::ST_SCAN_RD;
				else                               state_d = prpe_pkg::ST_CNT_RD;
			end
			prpe_pkg::ST_SCAN_RD: state_d = prpe_pkg::ST_SCAN;
			prpe_pkg::ST_SCAN: begin
				if (search_last) state_d = prpe_pkg::ST_EVICT;
			end
			prpe_pkg::ST_EVICT:  state_d = prpe_pkg::ST_CNT_RD;
			prpe_pkg::ST_CNT_RD: state_d = prpe_pkg::ST_CNT_WR;
			prpe_pkg::ST_CNT_WR: state_d = prpe_pkg::ST_IDLE;
			default:             state_d = prpe_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: frame port, counter port, handshake
	always_comb begin
		frm_cmd.shift = 1'b0;
		frm_cmd.page  = page_q;
		frm_pos       = '0;
		frm_rd_idx    = j_q[IW-1:0];
		cnt_cmd.clear_all = 1'b0;
		cnt_cmd.wr_en     = 1'b0;
		cnt_rd_addr   = ci_q;
		busy          = 1'b1;
		unique case (state_q)
			prpe_pkg::ST_IDLE: begin
				busy              = 1'b0;
				cnt_cmd.clear_all = start && first_of_run;
			end
			prpe_pkg::ST_SEARCH: ;
			prpe_pkg::ST_DECIDE: begin
				frm_rd_idx = count_m1[IW-1:0];
				if (hit_q) begin
					frm_cmd.shift = lru_q;
					frm_pos       = slot_q;
				end else if (room) begin
					frm_cmd.shift = 1'b1;
					frm_pos       = count_q[IW-1:0];
				end else if (!count_mode) begin
					frm_cmd.shift = 1'b1;
					frm_pos       = count_m1[IW-1:0];
				end
			end
			prpe_pkg::ST_SCAN_RD: begin
				frm_rd_idx  = '0;
				cnt_rd_addr = ci_rd;
			end
			prpe_pkg::ST_SCAN: begin
				frm_rd_idx  = j_p1[IW-1:0];
				cnt_rd_addr = ci_rd;
			end
			prpe_pkg::ST_EVICT: begin
				frm_rd_idx    = pick_q;
				frm_cmd.shift = 1'b1;
				frm_pos       = pick_q;
			end
			prpe_pkg::ST_CNT_RD: ;
			prpe_pkg::ST_CNT_WR: cnt_cmd.wr_en = 1'b1;
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= prpe_pkg::ST_IDLE;
			count_q    <= '0;
			j_q        <= '0;
			faults_q   <= '0;
			repl_q     <= '0;
			hit_q      <= 1'b0;
			replaced_q <= 1'b0;
			zero_q     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == prpe_pkg::ST_CNT_WR);
			unique case (state_q)
				prpe_pkg::ST_IDLE: begin
					if (accept) begin
						j_q        <= '0;
						hit_q      <= 1'b0;
						replaced_q <= 1'b0;
						zero_q     <= 1'b0;
						if (first_of_run) begin
							count_q  <= '0;
							faults_q <= '0;
							repl_q   <= '0;
						end
					end
				end
				prpe_pkg::ST_SEARCH: begin
					if (match) hit_q <= 1'b1;
					j_q <= j_p1;
				end
				prpe_pkg::ST_DECIDE: begin
					if (!hit_q) begin
						if (faults_q != '1) faults_q <= faults_q + 1'b1;
						if (room) begin
							count_q <= count_q + 1'b1;
						end else begin
							replaced_q <= 1'b1;
							if (repl_q != '1) repl_q <= repl_q + 1'b1;
						end
					end
				end
				prpe_pkg::ST_SCAN_RD: j_q <= '0;
				prpe_pkg::ST_SCAN:    j_q <= j_p1;
				prpe_pkg::ST_EVICT:   zero_q <= 1'b1;
				prpe_pkg::ST_CNT_RD: ;
				prpe_pkg::ST_CNT_WR: ;
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			prpe_pkg::ST_IDLE: begin
				if (accept) begin
					page_q   <= page_id;
					ci_q     <= ci_in;
					limit_q  <= limit_in;
					lru_q    <= (mode_eff == prpe_pkg::MODE_LRU) ||
					            (mode_eff == prpe_pkg::MODE_LFU_LRU) ||
					            (mode_eff == prpe_pkg::MODE_MFU_LRU);
					least_q  <= (mode_eff == prpe_pkg::MODE_LFU) ||
					            (mode_eff == prpe_pkg::MODE_LFU_LRU);
					most_q   <= (mode_eff == prpe_pkg::MODE_MFU) ||
					            (mode_eff == prpe_pkg::MODE_MFU_LRU);
					slot_q   <= '0;
					victim_q <= '0;
				end
			end
			prpe_pkg::ST_SEARCH: begin
				if (match) slot_q <= j_q[IW-1:0];
			end
			prpe_pkg::ST_DECIDE: begin
				if (!hit_q && !room && !count_mode) victim_q <= frm_rd_page;
			end
			prpe_pkg::ST_SCAN_RD: begin
				alias_s1 <= (ci_rd == ci_q);
				pick_q   <= '0;
			end
			prpe_pkg::ST_SCAN: begin
				alias_s1 <= (ci_rd == ci_q);
				if (take) begin
					best_q <= c_val;
					pick_q <= j_q[IW-1:0];
				end else begin
					best_q <= best_eff;
				end
			end
			prpe_pkg::ST_EVICT: victim_q <= frm_rd_page;
			prpe_pkg::ST_CNT_RD: ;
			prpe_pkg::ST_CNT_WR: ;
			default: ;
		endcase
	end

	// Result beat
	assign slot_ext  = {{(CW+4-IW){1'b0}}, slot_q};
	assign count_ext = {4'd0, count_q};

	assign done            = done_q;
	assign was_fault       = !hit_q;
	assign was_replaced    = replaced_q;
	assign victim_page     = replaced_q ? victim_q : '0;
	assign hit_slot        = hit_q ? slot_ext[2:0] : 3'd0;
	assign occupied_frames = count_ext[3:0];
	assign fault_total     = faults_q;
	assign replace_total   = repl_q;

endmodule

// ===== bench/frame_policy_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_policy_checker
// Watches the reference, result and register channels of the page
// replacement engine. Mirrors the policy registers from bus writes, replays
// every accepted page reference on its own frame list and counter table,
// and compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module frame_policy_checker #(
	parameter int MAX_FRAMES = 8,
	parameter int PAGE_IDS   = 256,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [7:0]  page_id,
	input  logic        first_of_run,
	input  logic        done,
	input  logic        was_fault,
	input  logic        was_replaced,
	input  logic [7:0]  victim_page,
	input  logic [2:0]  hit_slot,
	input  logic [3:0]  occupied_frames,
	input  logic [31:0] fault_total,
	input  logic [31:0] replace_total,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          errors,
	output int          outstanding
);

	typedef struct packed {
		logic        fault;
		logic        replaced;
		logic [7:0]  victim;
		logic [2:0]  slot;
		logic [3:0]  occupied;
		logic [31:0] faults;
		logic [31:0] replacements;
	} ref_outcome_t;

	localparam logic [COUNT_BITS-1:0] COUNT_SAT = {COUNT_BITS{1'b1}};

	logic [2:0]            mode_reg;
	logic [3:0]            frames_reg;
	logic [7:0]            frame_q [MAX_FRAMES];
	int                    resident;
	logic [COUNT_BITS-1:0] ref_count [PAGE_IDS];
	logic [31:0]           fault_sum;
	logic [31:0]           evict_sum;
	ref_outcome_t          pending_outcomes [$];

	// Drop every frame, counter and total
	function automatic void clear_run();
		for (int k = 0; k < MAX_FRAMES; k++)
			frame_q[k] = '0;
		for (int k = 0; k < PAGE_IDS; k++)
			ref_count[k] = '0;
		resident = 0;
		fault_sum = '0;
		evict_sum = '0;
	endfunction

	// Remove the entry at pos and push pg in at the front
	function automatic void shift_in(int pos, logic [7:0] pg);
		for (int k = pos; k > 0; k--)
			frame_q[k] = frame_q[k-1];
		frame_q[0] = pg;
	endfunction

	// Apply one page reference to the mirrored state and return its outcome
	function automatic ref_outcome_t replay_reference(logic [7:0] pg, logic fr);
		logic [2:0]            pol;
		logic                  by_recency;
		logic                  want_least;
		logic                  want_most;
		logic                  hit;
		logic                  replaced;
		logic [7:0]            victim;
		logic [COUNT_BITS-1:0] best;
		logic [COUNT_BITS-1:0] c;
		int                    lim;
		int                    slot;
		int                    pick;
		int                    idx;
		ref_outcome_t          o;

		pol = (mode_reg > prpe_pkg::MODE_MFU_LRU) ? prpe_pkg::MODE_FIFO : mode_reg;
		by_recency = (pol == prpe_pkg::MODE_LRU) || (pol == prpe_pkg::MODE_LFU_LRU) ||
		             (pol == prpe_pkg::MODE_MFU_LRU);
		want_least = (pol == prpe_pkg::MODE_LFU) || (pol == prpe_pkg::MODE_LFU_LRU);
		want_most = (pol == prpe_pkg::MODE_MFU) || (pol == prpe_pkg::MODE_MFU_LRU);
		lim = int'(frames_reg);
		if (lim == 0)
			lim = 1;
		if (lim > MAX_FRAMES)
			lim = MAX_FRAMES;
		idx = int'(pg) % PAGE_IDS;
		hit = 1'b0;
		replaced = 1'b0;
		victim = '0;
		slot = 0;

		if (fr)
			clear_run();

		// search the resident list
		for (int j = 0; j < resident; j++) begin
			if (frame_q[j] == pg) begin
				hit = 1'b1;
				slot = j;
			end
		end

		if (!hit) begin
			if (fault_sum != 32'hFFFF_FFFF)
				fault_sum++;
			if (resident < lim) begin
				shift_in(resident, pg);
				resident++;
			end else begin
				// full: pick the victim, back entry unless a count policy
				pick = resident - 1;
				replaced = 1'b1;
				if (evict_sum != 32'hFFFF_FFFF)
					evict_sum++;
				if (want_least || want_most) begin
					best = ref_count[int'(frame_q[0]) % PAGE_IDS];
					ref_count[idx] = '0;
					pick = 0;
					for (int j = 0; j < resident; j++) begin
						c = ref_count[int'(frame_q[j]) % PAGE_IDS];
						if ((want_least && c <= best) || (want_most && c >= best)) begin
							best = c;
							pick = j;
						end
					end
				end
				victim = frame_q[pick];
				shift_in(pick, pg);
			end
		end else if (by_recency) begin
			shift_in(slot, pg);
		end

		if (ref_count[idx] != COUNT_SAT)
			ref_count[idx]++;

		o.fault = !hit;
		o.replaced = replaced;
		o.victim = replaced ? victim : 8'd0;
		o.slot = hit ? slot[2:0] : 3'd0;
		o.occupied = resident[3:0];
		o.faults = fault_sum;
		o.replacements = evict_sum;
		return o;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Track register writes, score result beats, queue predictions
	always @(posedge clk or negedge arst_n) begin
		ref_outcome_t want;
		if (!arst_n) begin
			mode_reg = prpe_pkg::POLICY_MODE_RST;
			frames_reg = prpe_pkg::FRAMES_IN_USE_RST;
			clear_run();
			pending_outcomes.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == prpe_pkg::REG_POLICY_MODE)
					mode_reg = pwdata[2:0];
				else
					frames_reg = pwdata[3:0];
			end
			if (done) begin
				if (pending_outcomes.size() == 0) begin
					$error("result beat with no reference outstanding");
					errors++;
				end else begin
					want = pending_outcomes.pop_front();
					check_field("was_fault", want.fault, was_fault);
					check_field("was_replaced", want.replaced, was_replaced);
					check_field("victim_page", want.victim, victim_page);
					check_field("hit_slot", want.slot, hit_slot);
					check_field("occupied_frames", want.occupied, occupied_frames);
					check_field("fault_total", want.faults, fault_total);
					check_field("replace_total", want.replacements, replace_total);
				end
			end
			// append the prediction behind the older ones
			if (start && !busy)
				pending_outcomes.insert(pending_outcomes.size(),
				                        replay_reference(page_id, first_of_run));
			outstanding = pending_outcomes.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives page references and policy register writes into the page
// replacement engine: a directed pass over list edges and every policy, a
// short run that makes one page far busier, then random reference streams
// with small working sets under changing policies and frame limits.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int           HALF_PERIOD   = 10;
	localparam int           TOTAL_RANDOM  = 1100;
	localparam int           CALM_FROM     = 950;
	localparam int           BUSY_REFS     = 40;
	localparam logic [2:0]   MODE_SPARE_LO = 3'd6;
	localparam logic [2:0]   MODE_SPARE_HI = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  page_id;
	logic        first_of_run;
	logic        done;
	logic        was_fault;
	logic        was_replaced;
	logic [7:0]  victim_page;
	logic [2:0]  hit_slot;
	logic [3:0]  occupied_frames;
	logic [31:0] fault_total;
	logic [31:0] replace_total;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          chk_errors;
	int          in_flight;

	page_replacement_policy_engine i_dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .page_id(page_id), .first_of_run(first_of_run),
		.done(done), .was_fault(was_fault), .was_replaced(was_replaced),
		.victim_page(victim_page), .hit_slot(hit_slot), .occupied_frames(occupied_frames),
		.fault_total(fault_total), .replace_total(replace_total),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	frame_policy_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .page_id(page_id), .first_of_run(first_of_run),
		.done(done), .was_fault(was_fault), .was_replaced(was_replaced),
		.victim_page(victim_page), .hit_slot(hit_slot), .occupied_frames(occupied_frames),
		.fault_total(fault_total), .replace_total(replace_total),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.errors(chk_errors), .outstanding(in_flight)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Hard stop if the engine hangs
	initial begin
		#100_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Hold a reference on the command lines until the engine takes it
	task automatic send_ref(input logic [7:0] pg, input logic fr);
		start <= 1'b1;
		page_id <= pg;
		first_of_run <= fr;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	task automatic pause_for(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Stop issuing and wait for every outstanding result beat
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (in_flight != 0)
			@(negedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// Mostly a small working set so hits and evictions dominate
	task automatic random_stream(input int n_items, input bit gaps);
		int        pool_base;
		int        pool_size;
		logic [7:0] pg;
		logic      fr;
		pool_size = $urandom_range(2, 12);
		pool_base = $urandom_range(0, 255);
		for (int k = 0; k < n_items; k++) begin
			if ($urandom_range(0, 99) < 85)
				pg = 8'(pool_base + $urandom_range(0, pool_size - 1));
			else
				pg = 8'($urandom_range(0, 255));
			if (k == 0)
				fr = 1'($urandom_range(0, 1));
			else
				fr = ($urandom_range(0, 99) < 2);
			if (gaps && $urandom_range(0, 99) < 25)
				pause_for($urandom_range(1, 12));
			send_ref(pg, fr);
		end
	endtask

	initial begin
		int          issued;
		int          chunk;
		int          pick;
		int          waited;
		logic [3:0]  lim;

		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		page_id = '0;
		first_of_run = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fifo, eight frames: fill, hit near and at the back, evict the back
		send_ref(8'd0, 1'b1);
		send_ref(8'd255, 1'b0);
		send_ref(8'd1, 1'b0);
		send_ref(8'd2, 1'b0);
		send_ref(8'd4, 1'b0);
		send_ref(8'd8, 1'b0);
		send_ref(8'd16, 1'b0);
		send_ref(8'd32, 1'b0);
		send_ref(8'd255, 1'b0);
		send_ref(8'd64, 1'b0);
		send_ref(8'd255, 1'b0);
		send_ref(8'd128, 1'b0);

		// lower the frame limit under a full list, then an lru replacement
		drain();
		cfg_write(prpe_pkg::REG_FRAMES_IN_USE, 32'd3);
		send_ref(8'd100, 1'b0);
		drain();
		cfg_write(prpe_pkg::REG_POLICY_MODE, {29'd0, prpe_pkg::MODE_LRU});
		send_ref(8'd1, 1'b0);

		// count policies on two frames, lfu then mfu replacement
		drain();
		cfg_write(prpe_pkg::REG_POLICY_MODE, {29'd0, prpe_pkg::MODE_LFU});
		cfg_write(prpe_pkg::REG_FRAMES_IN_USE, 32'd2);
		send_ref(8'd5, 1'b1);
		send_ref(8'd5, 1'b0);
		send_ref(8'd6, 1'b0);
		send_ref(8'd7, 1'b0);
		drain();
		cfg_write(prpe_pkg::REG_POLICY_MODE, {29'd0, prpe_pkg::MODE_MFU});
		send_ref(8'd8, 1'b0);

		// frame limit extremes and the recency-ordered count modes
		drain();
		cfg_write(prpe_pkg::REG_POLICY_MODE, {29'd0, prpe_pkg::MODE_LFU_LRU});
		cfg_write(prpe_pkg::REG_FRAMES_IN_USE, 32'd0);
		send_ref(8'd9, 1'b1);
		send_ref(8'd10, 1'b0);
		drain();
		cfg_write(prpe_pkg::REG_POLICY_MODE, {29'd0, prpe_pkg::MODE_MFU_LRU});
		cfg_write(prpe_pkg::REG_FRAMES_IN_USE, 32'd15);
		send_ref(8'd11, 1'b0);
		send_ref(8'd11, 1'b0);

		// unused policy codes fall back to fifo
		drain();
		cfg_write(prpe_pkg::REG_POLICY_MODE, {29'd0, MODE_SPARE_LO});
		send_ref(8'd12, 1'b0);
		drain();
		cfg_write(prpe_pkg::REG_POLICY_MODE, {29'd0, MODE_SPARE_HI});
		send_ref(8'd13, 1'b0);

		// make one page far busier, then lfu must evict the other one
		drain();
		cfg_write(prpe_pkg::REG_POLICY_MODE, {29'd0, prpe_pkg::MODE_LFU});
		cfg_write(prpe_pkg::REG_FRAMES_IN_USE, 32'd2);
		send_ref(8'd20, 1'b1);
		send_ref(8'd21, 1'b0);
		repeat (BUSY_REFS) send_ref(8'd20, 1'b0);
		repeat (10) send_ref(8'd21, 1'b0);
		send_ref(8'd22, 1'b0);

		// random streams, settings changed only with the engine drained
		issued = 0;
		while (issued < TOTAL_RANDOM) begin
			chunk = $urandom_range(30, 90);
			if (issued + chunk > TOTAL_RANDOM)
				chunk = TOTAL_RANDOM - issued;
			drain();
			if ($urandom_range(0, 3) != 0)
				cfg_write(prpe_pkg::REG_POLICY_MODE, 32'($urandom_range(0, 7)));
			if ($urandom_range(0, 3) != 0) begin
				pick = $urandom_range(0, 9);
				if (pick == 8)
					lim = 4'd0;
				else if (pick == 9)
					lim = 4'($urandom_range(9, 15));
				else
					lim = 4'($urandom_range(1, 8));
				cfg_write(prpe_pkg::REG_FRAMES_IN_USE, {28'd0, lim});
			end
			random_stream(chunk, (issued < CALM_FROM) && ($urandom_range(0, 3) != 0));
			issued += chunk;
		end

		// let the last results come out
		start <= 1'b0;
		waited = 0;
		while (in_flight != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (30) @(negedge clk);
		if (in_flight != 0)
			$error("%0d references never produced a result", in_flight);
		if (chk_errors == 0 && in_flight == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/prpe_pkg.sv
rtl/prpe_regs.sv
rtl/prpe_frames.sv
rtl/prpe_cnt_mem.sv
rtl/page_replacement_policy_engine.sv
bench/frame_policy_checker.sv
bench/tb_top.sv
